>>> sv/qdbp_pkg.sv
// ============================================================================
// qdbp_pkg: shared types and constants for the 64-QAM demapper byte packer
// Holds the beat structs of both channels, the queue entry format and the
// Gray table that turns one odd level into three bits.
// ============================================================================
package qdbp_pkg;

    // Number of bits carried by one level and by one output byte.
    localparam int unsigned GRAY_BITS = 3;
    localparam int unsigned BYTE_BITS = 8;

    // Widths of the packing datapath: residue plus the bits of one I/Q symbol.
    localparam int unsigned RES_W = 7;
    localparam int unsigned ACC_W = RES_W + 2 * GRAY_BITS;
    localparam int unsigned CNT_W = 4;

    // Top bit flip applied to every emitted byte.
    localparam logic [7:0] MSB_FLIP = 8'h80;

    // Gray code of each level, indexed by (level + 7) / 2.
    localparam logic [2:0] GRAY_CODE [8] = '{
        3'd0, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd7
    };

    // Input beat: one symbol.
    typedef struct packed {
        logic signed [7:0] i_level;
        logic signed [7:0] q_level;
    } sym_beat_t;

    // Output beat: one result per symbol.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       i_invalid;
        logic       q_invalid;
    } res_beat_t;

    // Classified symbol held in the queue between front and back.
    typedef struct packed {
        logic       i_ok;
        logic [2:0] i_bits;
        logic       q_ok;
        logic [2:0] q_bits;
    } sym_entry_t;

    // Level is valid when odd and within -7..7.
    function automatic logic level_ok(input logic signed [7:0] level);
        return (level >= -8'sd7) && (level <= 8'sd7) && level[0];
    endfunction

    // Gray bits of a valid level; meaningless for other levels.
    function automatic logic [2:0] level_bits(input logic signed [7:0] level);
        logic [7:0] sum;
        sum = 8'(level + 8'sd7);
        return GRAY_CODE[sum[3:1]];
    endfunction

endpackage

>>> sv/qdbp_front.sv
// ============================================================================
// qdbp_front: symbol classifier
// Checks each level against the constellation and looks up its Gray bits.
// ============================================================================
module qdbp_front (
    input  qdbp_pkg::sym_beat_t  sym,
    output qdbp_pkg::sym_entry_t entry
);
    import qdbp_pkg::*;

    // Classify both levels of the symbol independently.
    always_comb
    begin
        entry.i_ok   = level_ok(sym.i_level);
        entry.i_bits = level_bits(sym.i_level);
        entry.q_ok   = level_ok(sym.q_level);
        entry.q_bits = level_bits(sym.q_level);
    end

endmodule

>>> sv/qdbp_queue.sv
// ============================================================================
// qdbp_queue: two-entry queue of classified symbols
// Decouples the classifier from the packer so each side stalls on its own.
// ============================================================================
module qdbp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  qdbp_pkg::sym_entry_t push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output qdbp_pkg::sym_entry_t head
);
    import qdbp_pkg::*;

    sym_entry_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    // Status flags and head of the queue.
    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/qdbp_back.sv
// ============================================================================
// qdbp_back: bit packer
// Appends the Gray bits of each classified symbol to the residue, cuts off
// a byte when eight bits are held and keeps the result in an output register.
// ============================================================================
module qdbp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 entry_valid,
    input  qdbp_pkg::sym_entry_t entry,
    output logic                 entry_pop,
    output qdbp_pkg::res_beat_t  res,
    output logic                 res_valid,
    input  logic                 res_stall
);
    import qdbp_pkg::*;

    logic [RES_W-1:0] residue_bits_reg;
    logic [RES_W-1:0] residue_bits_next;
    logic [2:0]       residue_count_reg;
    logic [2:0]       residue_count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    res_beat_t        out_reg;
    res_beat_t        out_next;

    logic [ACC_W-1:0] acc_i;
    logic [ACC_W-1:0] acc_q;
    logic [CNT_W-1:0] cnt_i;
    logic [CNT_W-1:0] cnt_q;
    logic [CNT_W-1:0] cnt_left;
    logic [ACC_W-1:0] keep_mask;
    logic             load;

    // Take a new entry whenever the output register is free or drains now.
    assign load      = entry_valid && (!out_valid_reg || !res_stall);
    assign entry_pop = load;
    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    // Append I bits, then Q bits, and split off a full byte.
    always_comb
    begin
        acc_i = {{(ACC_W - RES_W){1'b0}}, residue_bits_reg};
        cnt_i = {1'b0, residue_count_reg};
        if (entry.i_ok)
        begin
            acc_i = {acc_i[ACC_W-GRAY_BITS-1:0], entry.i_bits};
            cnt_i = cnt_i + CNT_W'(GRAY_BITS);
        end
        acc_q = acc_i;
        cnt_q = cnt_i;
        if (entry.q_ok)
        begin
            acc_q = {acc_i[ACC_W-GRAY_BITS-1:0], entry.q_bits};
            cnt_q = cnt_i + CNT_W'(GRAY_BITS);
        end

        out_next.i_invalid  = !entry.i_ok;
        out_next.q_invalid  = !entry.q_ok;
        out_next.byte_valid = 1'b0;
        out_next.out_byte   = 8'd0;
        cnt_left            = cnt_q;
        if (cnt_q >= CNT_W'(BYTE_BITS))
        begin
            cnt_left            = cnt_q - CNT_W'(BYTE_BITS);
            out_next.byte_valid = 1'b1;
            out_next.out_byte   = 8'(acc_q >> cnt_left) ^ MSB_FLIP;
        end
        keep_mask          = (ACC_W'(1) << cnt_left) - ACC_W'(1);
        residue_bits_next  = RES_W'(acc_q & keep_mask);
        residue_count_next = cnt_left[2:0];
    end

    // Output valid follows loads and drains.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residue_bits_reg  <= '0;
            residue_count_reg <= 3'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                residue_bits_reg  <= residue_bits_next;
                residue_count_reg <= residue_count_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> sv/qam64_demap_byte_pack.sv
// ============================================================================
// qam64_demap_byte_pack: 64-QAM Gray demapper with byte packing
// Turns I/Q symbol levels into Gray bits and packs them into bytes.
// ============================================================================
// Usage:
//   Input channel sym/sym_valid/sym_stall carries one symbol per beat as
//   signed I and Q levels. Output channel res/res_valid/res_stall returns
//   exactly one result beat per symbol, in order: a byte flag, the byte
//   with its top bit inverted, and an invalid flag for each level.
//   A level that is not odd in -7..7 adds no bits and sets its flag.
//   An accepted symbol is held in the queue, and its result is registered
//   in the output register before it is shown.
//   Throughput is one symbol per cycle while res_stall is low, set by the
//   packer that updates the residue for each symbol it takes from the queue.
//   A two-entry queue sits between the classifier and the packer; when the
//   receiver stalls, the output register holds its beat, the queue fills,
//   and sym_stall rises once both queue entries are taken.
//   Reset clears the residue (no pending bits), the queue and the output
//   valid; bits that never complete a byte are kept and never emitted.
// ============================================================================
module qam64_demap_byte_pack (
    input  logic                clk,
    input  logic                rst_n,
    input  qdbp_pkg::sym_beat_t sym,
    input  logic                sym_valid,
    output logic                sym_stall,
    output qdbp_pkg::res_beat_t res,
    output logic                res_valid,
    input  logic                res_stall
);
    import qdbp_pkg::*;

    sym_entry_t front_entry;
    sym_entry_t queue_head;
    logic       queue_full;
    logic       queue_not_empty;
    logic       queue_pop;
    logic       queue_push;

    // Accept a beat whenever the queue has room.
    assign sym_stall  = queue_full;
    assign queue_push = sym_valid && !queue_full;

    qdbp_front u_front (
        .sym   (sym),
        .entry (front_entry)
    );

    qdbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (front_entry),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    qdbp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (queue_not_empty),
        .entry       (queue_head),
        .entry_pop   (queue_pop),
        .res         (res),
        .res_valid   (res_valid),
        .res_stall   (res_stall)
    );

endmodule

>>> bench/qam64_demap_byte_pack_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// qam64_demap_byte_pack_tb: self-checking bench for the 64-QAM byte packer
// Drives symbol beats through the valid/stall input channel and checks every
// result beat against a local model of the Gray demapper and the residue
// packer or a row's want. A short directed table runs first. Random symbols
// follow, mostly legal odd levels with some out-of-table noise. Both sides
// idle in random bursts, and the last stretch of the run runs without gaps.
// ============================================================================
module qam64_demap_byte_pack_tb;

    import qdbp_pkg::*;

    // Gray code of each legal level, indexed by (level + 7) / 2.
    localparam logic [2:0] LEVEL_GRAY [8] = '{
        3'd0, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd7
    };
    localparam logic [7:0] TOP_BIT_FLIP = 8'h80;
    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM = 550;
    localparam int CALM_TAIL = 60;
    localparam int NOISE_PCT = 12;

    // One row of the directed table; want is used only when has_want is set.
    typedef struct packed {
        sym_beat_t sym;
        logic      has_want;
        res_beat_t want;
    } sym_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    sym_beat_t sym = '0;
    logic      sym_valid = 1'b0;
    logic      sym_stall;
    res_beat_t res;
    logic      res_valid;
    logic      res_stall = 1'b0;

    // Local copy of the packer state.
    logic [6:0] pack_residue = '0;
    logic [2:0] pack_count = '0;

    res_beat_t   expected_results [$];
    int unsigned failures = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned stall_left = 0;

    // Reset state, table extremes, every legal level and the invalid cases.
    sym_row_t directed_rows [N_DIRECTED] = '{
        '{'{8'h80, 8'sd127}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}},
        '{'{8'sd0, -8'sd8}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}},
        '{'{8'sd8, -8'sd2}, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1}},
        '{'{-8'sd7, -8'sd7}, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
        '{'{-8'sd7, -8'sd7}, 1'b1, '{1'b1, 8'h80, 1'b0, 1'b0}},
        '{'{8'sd7, 8'sd7}, 1'b0, '0},
        '{'{-8'sd5, 8'sd5}, 1'b0, '0},
        '{'{-8'sd3, 8'sd3}, 1'b0, '0},
        '{'{-8'sd1, 8'sd1}, 1'b0, '0},
        '{'{8'sd1, -8'sd1}, 1'b0, '0},
        '{'{8'sd3, -8'sd3}, 1'b0, '0},
        '{'{8'sd5, -8'sd5}, 1'b0, '0},
        '{'{8'sd6, 8'sd5}, 1'b0, '0},
        '{'{-8'sd3, -8'sd9}, 1'b0, '0},
        '{'{8'sd9, -8'sd6}, 1'b0, '0},
        '{'{8'sd127, 8'h80}, 1'b0, '0},
        '{'{8'sd7, 8'h81}, 1'b0, '0},
        '{'{8'h81, 8'sd7}, 1'b0, '0},
        '{'{-8'sd1, -8'sd1}, 1'b0, '0},
        '{'{8'sd1, 8'sd1}, 1'b0, '0}
    };

    qam64_demap_byte_pack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym       (sym),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .res       (res),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Table index of a level, or -1 when the level is even or beyond +-7.
    function automatic int gray_index(input logic signed [7:0] level);
        if (level < -8'sd7 || level > 8'sd7 || !level[0])
            return -1;
        return (int'(level) + 7) / 2;
    endfunction

    // Appends the Gray bits of one symbol and pops a byte once eight are held.
    function automatic res_beat_t demap_and_pack(input sym_beat_t s);
        logic [12:0] acc;
        logic [3:0]  cnt;
        int          idx_i;
        int          idx_q;
        res_beat_t   r;
        acc = {6'b0, pack_residue};
        cnt = {1'b0, pack_count};
        idx_i = gray_index(s.i_level);
        idx_q = gray_index(s.q_level);
        r = '0;
        if (idx_i >= 0)
        begin
            acc = (acc << 3) | 13'(LEVEL_GRAY[idx_i]);
            cnt = cnt + 4'd3;
        end
        else
            r.i_invalid = 1'b1;
        if (idx_q >= 0)
        begin
            acc = (acc << 3) | 13'(LEVEL_GRAY[idx_q]);
            cnt = cnt + 4'd3;
        end
        else
            r.q_invalid = 1'b1;
        if (cnt >= 4'd8)
        begin
            cnt = cnt - 4'd8;
            r.out_byte = 8'(acc >> cnt) ^ TOP_BIT_FLIP;
            r.byte_valid = 1'b1;
        end
        acc = acc & ((13'd1 << cnt) - 13'd1);
        pack_residue = acc[6:0];
        pack_count = cnt[2:0];
        return r;
    endfunction

    // A legal odd level most of the time, any 8-bit value otherwise.
    function automatic logic [7:0] random_level();
        if ($urandom_range(0, 99) < NOISE_PCT)
            return 8'($urandom_range(0, 255));
        return 8'(2 * $urandom_range(0, 7) - 7);
    endfunction

    // Idle rate of one stretch: none, light or heavy.
    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 45;
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
        end
    endtask

    // Offers one symbol beat, maybe after an idle burst, and records the
    // expected result once the beat is taken.
    task automatic send_symbol(input sym_beat_t s, input logic has_want,
                               input res_beat_t want);
        res_beat_t   pred;
        int unsigned gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 11);
            sym_valid <= 1'b0;
            sym <= sym_beat_t'(16'($urandom));
            repeat (gap) @(posedge clk);
        end
        sym <= s;
        sym_valid <= 1'b1;
        @(posedge clk);
        while (sym_stall)
            @(posedge clk);
        pred = demap_and_pack(s);
        expected_results.insert(expected_results.size(), has_want ? want : pred);
    endtask

    // Result side: check each accepted beat and stall in random bursts.
    always @(posedge clk)
    begin
        res_beat_t want;
        if (res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no symbol pending");
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("byte_valid", int'(want.byte_valid), int'(res.byte_valid));
                check_field("out_byte", int'(want.out_byte), int'(res.out_byte));
                check_field("i_invalid", int'(want.i_invalid), int'(res.i_invalid));
                check_field("q_invalid", int'(want.q_invalid), int'(res.q_invalid));
            end
        end
        if (stall_left != 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 10);
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    // Stimulus: reset, directed table, random symbols, then drain.
    initial
    begin
        sym_beat_t s;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        gap_pct = 25;
        stall_pct = 25;
        for (int i = 0; i < N_DIRECTED; i++)
            send_symbol(directed_rows[i].sym, directed_rows[i].has_want,
                        directed_rows[i].want);

        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k >= N_RANDOM - CALM_TAIL)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else if (k % 50 == 0)
            begin
                gap_pct = pick_idle_pct();
                stall_pct = pick_idle_pct();
            end
            s.i_level = random_level();
            s.q_level = random_level();
            send_symbol(s, 1'b0, '0);
        end
        sym_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
